### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property, disabled while reset is low
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_PROP(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_PROP(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

### sv/mprq_pkg.sv
// ---------------------------------------------------------------------------
// mprq_pkg
// Shared types and constants for the median edge predictor / quantizer.
// ---------------------------------------------------------------------------
package mprq_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int NUM_CH     = 3;
    localparam int PIX_W      = 8;
    localparam int RES_W      = 9;
    localparam int DIM_W      = 12;
    localparam int QB_W       = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int SHIFT_W    = 3;

    localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd480;
    localparam logic [QB_W-1:0]  RST_QBITS  = 4'd8;
    localparam logic [QB_W-1:0]  QBITS_MAX  = 4'd8;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_QUANT_BITS   = 3'd2,
        CFG_DECODE_MODE  = 3'd3,
        CFG_GRAY_MODE    = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic               decode;
        logic               active;
        logic [SHIFT_W-1:0] qshift;
    } t_chan_ctl;

endpackage

### sv/mprq_chan.sv
// ---------------------------------------------------------------------------
// mprq_chan
// One colour channel: median edge prediction, residual quantize or rebuild.
// ---------------------------------------------------------------------------
module mprq_chan
    import mprq_pkg::*;
(
    input  t_chan_ctl                i_ctl,
    input  logic [PIX_W-1:0]         i_a,
    input  logic [PIX_W-1:0]         i_b,
    input  logic [PIX_W-1:0]         i_c,
    input  logic [PIX_W-1:0]         i_pixel,
    input  logic signed [RES_W-1:0]  i_resid,
    output logic signed [RES_W-1:0]  o_resid,
    output logic [PIX_W-1:0]         o_recon,
    output logic [PIX_W-1:0]         o_stored
);

    logic [PIX_W-1:0]   mx;
    logic [PIX_W-1:0]   mn;
    logic [PIX_W+1:0]   grad;
    logic [PIX_W-1:0]   pred;
    logic [RES_W-1:0]   diff;
    logic [RES_W-1:0]   diff_neg;
    logic [PIX_W-1:0]   mag;
    logic [PIX_W-1:0]   mag_q;
    logic [RES_W-1:0]   quant;
    logic [PIX_W+1:0]   sum;
    logic [PIX_W-1:0]   rebuilt;

    always_comb begin
        mx   = (i_a > i_b) ? i_a : i_b;
        mn   = (i_a > i_b) ? i_b : i_a;
        grad = {2'b00, i_a} + {2'b00, i_b} - {2'b00, i_c};
        if (i_c >= mx) begin
            pred = mn;
        end else if (i_c <= mn) begin
            pred = mx;
        end else begin
            // c strictly between a and b keeps a+b-c inside 0..255
            pred = grad[PIX_W-1:0];
        end

        // truncate toward zero: mask the magnitude, then restore the sign
        diff     = {1'b0, i_pixel} - {1'b0, pred};
        diff_neg = -diff;
        mag      = diff[RES_W-1] ? diff_neg[PIX_W-1:0] : diff[PIX_W-1:0];
        mag_q    = mag & (PIX_MAX << i_ctl.qshift);
        quant    = diff[RES_W-1] ? -{1'b0, mag_q} : {1'b0, mag_q};

        sum = {2'b00, pred} + {i_resid[RES_W-1], i_resid};
        if (sum[PIX_W+1]) begin
            rebuilt = '0;
        end else if (sum[PIX_W]) begin
            rebuilt = PIX_MAX;
        end else begin
            rebuilt = sum[PIX_W-1:0];
        end

        o_resid  = (i_ctl.active && !i_ctl.decode) ? quant : '0;
        o_recon  = (i_ctl.active && i_ctl.decode) ? rebuilt : '0;
        if (!i_ctl.active) begin
            o_stored = '0;
        end else if (i_ctl.decode) begin
            o_stored = rebuilt;
        end else begin
            o_stored = i_pixel;
        end
    end

endmodule

### sv/med_predict_residual_quantize_top.sv
// An accepted pixel is registered into stage 1, then into the output register.
// Throughput: one pixel per cycle unless the output stalls; the line buffer read
// and write may share a cycle, with a forward path when a row is a single pixel wide.
// Reset: synchronous, active low; clears counters, neighbour registers, valids
// and config to defaults. The line buffer is not cleared.
// ---------------------------------------------------------------------------
// med_predict_residual_quantize_top
// Raster median edge predictor with residual quantize (encode) / rebuild (decode).
// ---------------------------------------------------------------------------
module med_predict_residual_quantize_top
    import mprq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [PIX_W-1:0]        i_pixel_c0,
    input  logic [PIX_W-1:0]        i_pixel_c1,
    input  logic [PIX_W-1:0]        i_pixel_c2,
    input  logic signed [RES_W-1:0] i_resid_in_c0,
    input  logic signed [RES_W-1:0] i_resid_in_c1,
    input  logic signed [RES_W-1:0] i_resid_in_c2,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [RES_W-1:0] o_resid_out_c0,
    output logic signed [RES_W-1:0] o_resid_out_c1,
    output logic signed [RES_W-1:0] o_resid_out_c2,
    output logic [PIX_W-1:0]        o_recon_c0,
    output logic [PIX_W-1:0]        o_recon_c1,
    output logic [PIX_W-1:0]        o_recon_c2,
    output logic                    o_end_of_frame
);

    localparam int WORD_W = NUM_CH * PIX_W;

    // config registers
    logic [DIM_W-1:0] r_cfg_width;
    logic [DIM_W-1:0] r_cfg_height;
    logic [QB_W-1:0]  r_cfg_qbits;
    logic             r_cfg_decode;
    logic             r_cfg_gray;

    // position
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W:0]   w_eff;
    logic [ROW_W:0]   h_eff;
    logic             last_col;
    logic             last_row;

    // stage 1: captured request plus line buffer read
    logic                    r_s1_vld, n_s1_vld;
    logic [PIX_W-1:0]        r_s1_pix [NUM_CH];
    logic signed [RES_W-1:0] r_s1_res [NUM_CH];
    logic [COL_W-1:0]        r_s1_addr;
    logic                    r_s1_xnz;
    logic                    r_s1_ynz;
    logic                    r_s1_eof;

    logic [WORD_W-1:0] r_mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rd;
    logic              r_byp;
    logic [WORD_W-1:0] r_byp_data;
    logic [WORD_W-1:0] top;

    logic [WORD_W-1:0] r_left;
    logic [WORD_W-1:0] r_upleft;
    logic [WORD_W-1:0] newpix;

    // output register
    logic                    r_out_vld, n_out_vld;
    logic signed [RES_W-1:0] r_out_res [NUM_CH];
    logic [PIX_W-1:0]        r_out_rec [NUM_CH];
    logic                    r_out_eof;

    logic                    out_free;
    logic                    s1_move;
    logic                    accept;
    logic [QB_W-1:0]         qb_eff;
    logic [QB_W-1:0]         qshift_w;
    logic [PIX_W-1:0]        in_pix [NUM_CH];
    logic signed [RES_W-1:0] in_res [NUM_CH];
    logic signed [RES_W-1:0] ch_res [NUM_CH];
    logic [PIX_W-1:0]        ch_rec [NUM_CH];
    logic [PIX_W-1:0]        ch_st  [NUM_CH];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_qbits  <= RST_QBITS;
            r_cfg_decode <= 1'b0;
            r_cfg_gray   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data[DIM_W-1:0];
                CFG_QUANT_BITS:   r_cfg_qbits  <= i_cfg_data[QB_W-1:0];
                CFG_DECODE_MODE:  r_cfg_decode <= i_cfg_data[0];
                CFG_GRAY_MODE:    r_cfg_gray   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // frame size and quant bits: zero counts as one, oversize saturates
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = (COL_W+1)'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = (COL_W+1)'(MAX_WIDTH);
        end else begin
            w_eff = (COL_W+1)'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = (ROW_W+1)'(1);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (ROW_W+1)'(r_cfg_height);
        end

        if (r_cfg_qbits == '0) begin
            qb_eff = QB_W'(1);
        end else if (r_cfg_qbits > QBITS_MAX) begin
            qb_eff = QBITS_MAX;
        end else begin
            qb_eff = r_cfg_qbits;
        end
        qshift_w = QBITS_MAX - qb_eff;
    end

    // handshake
    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_move    = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        last_col  = ((COL_W+1)'(r_col) + 1'b1) >= w_eff;
        last_row  = ((ROW_W+1)'(r_row) + 1'b1) >= h_eff;
        n_col     = r_col;
        n_row     = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        n_s1_vld  = accept ? 1'b1 : (s1_move ? 1'b0 : r_s1_vld);
        n_out_vld = out_free ? r_s1_vld : r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_left    <= '0;
            r_upleft  <= '0;
            r_byp     <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (s1_move) begin
                r_left   <= newpix;
                r_upleft <= top;
            end
            // same entry written as it is read: take the new word
            if (accept) begin
                r_byp <= s1_move && (r_s1_addr == r_col);
            end
        end
    end

    assign in_pix = '{i_pixel_c0, i_pixel_c1, i_pixel_c2};
    assign in_res = '{i_resid_in_c0, i_resid_in_c1, i_resid_in_c2};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= in_pix;
            r_s1_res  <= in_res;
            r_s1_addr <= r_col;
            r_s1_xnz  <= (r_col != '0);
            r_s1_ynz  <= (r_row != '0);
            r_s1_eof  <= last_col && last_row;
        end
    end

    // line buffer
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_mem[r_s1_addr] <= newpix;
        end
        if (accept) begin
            r_rd       <= r_mem[r_col];
            r_byp_data <= newpix;
        end
    end

    assign top = r_byp ? r_byp_data : r_rd;

    for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
        t_chan_ctl        ctl;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] c;

        always_comb begin
            ctl.decode = r_cfg_decode;
            ctl.active = (g == 0) || !r_cfg_gray;
            ctl.qshift = qshift_w[SHIFT_W-1:0];
            a = r_s1_xnz ? r_left[g*PIX_W +: PIX_W] : '0;
            b = r_s1_ynz ? top[g*PIX_W +: PIX_W] : '0;
            c = (r_s1_xnz && r_s1_ynz) ? r_upleft[g*PIX_W +: PIX_W] : '0;
        end

        mprq_chan u_chan (
            .i_ctl    (ctl),
            .i_a      (a),
            .i_b      (b),
            .i_c      (c),
            .i_pixel  (r_s1_pix[g]),
            .i_resid  (r_s1_res[g]),
            .o_resid  (ch_res[g]),
            .o_recon  (ch_rec[g]),
            .o_stored (ch_st[g])
        );

        assign newpix[g*PIX_W +: PIX_W] = ch_st[g];
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_res <= ch_res;
            r_out_rec <= ch_rec;
            r_out_eof <= r_s1_eof;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_resid_out_c0 = r_out_res[0];
    assign o_resid_out_c1 = r_out_res[1];
    assign o_resid_out_c2 = r_out_res[2];
    assign o_recon_c0     = r_out_rec[0];
    assign o_recon_c1     = r_out_rec[1];
    assign o_recon_c2     = r_out_rec[2];
    assign o_end_of_frame = r_out_eof;

endmodule

### sv/mprq_checker.sv
// ---------------------------------------------------------------------------
// mprq_checker
// Port-level checks on the predictor top level, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mprq_checker
    import mprq_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [RES_W-1:0] o_resid_out_c0,
    input logic signed [RES_W-1:0] o_resid_out_c1,
    input logic signed [RES_W-1:0] o_resid_out_c2,
    input logic [PIX_W-1:0]        o_recon_c0,
    input logic [PIX_W-1:0]        o_recon_c1,
    input logic [PIX_W-1:0]        o_recon_c2
);

    localparam logic signed [RES_W-1:0] RES_FLOOR = 9'sh100;

    logic out_blocked;
    logic recon_zero;
    logic resid_zero;
    logic resid_ok;

    assign out_blocked = o_out_valid && i_out_stall;
    assign recon_zero  = (o_recon_c0 == '0) && (o_recon_c1 == '0) && (o_recon_c2 == '0);
    assign resid_zero  = (o_resid_out_c0 == '0) && (o_resid_out_c1 == '0)
                         && (o_resid_out_c2 == '0);
    assign resid_ok    = (o_resid_out_c0 != RES_FLOOR) && (o_resid_out_c1 != RES_FLOOR)
                         && (o_resid_out_c2 != RES_FLOOR);

    // a waiting result is not dropped
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_blocked, o_out_valid, "result dropped")

    // input only backs up when the output register is full and stalled
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, out_blocked, "stall without cause")

    // one mode per result: residuals or rebuilt pixels, never both
    `ASSERT_IMPL(a_mode_excl, i_clk, i_rst_n, o_out_valid, recon_zero || resid_zero, "both modes set")

    // quantized residual stays within -255..255
    `ASSERT_IMPL(a_resid_range, i_clk, i_rst_n, o_out_valid, resid_ok, "residual out of range")

endmodule

bind med_predict_residual_quantize_top mprq_checker u_mprq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_resid_out_c0 (o_resid_out_c0),
    .o_resid_out_c1 (o_resid_out_c1),
    .o_resid_out_c2 (o_resid_out_c2),
    .o_recon_c0     (o_recon_c0),
    .o_recon_c1     (o_recon_c1),
    .o_recon_c2     (o_recon_c2)
);
